// File: rtl/utlw_pkg.sv
// package for the utf-8 text line width block
// holds command codes, code point constants and byte decode helpers
// no dependencies
package utlw_pkg;

    localparam logic [1:0] CMD_TEXT   = 2'd0;
    localparam logic [1:0] CMD_NARROW = 2'd1;
    localparam logic [1:0] CMD_GLYPH  = 2'd2;

    localparam int NARROW_ENTRIES = 256;
    localparam int NARROW_AW      = 8;
    localparam int CP_W           = 21;
    localparam int S_DATA_W       = 24;
    localparam int S_USER_W       = 3;
    localparam int M_DATA_W       = 24;

    localparam logic [CP_W-1:0] CP_SPACE   = CP_W'(32);
    localparam logic [CP_W-1:0] CP_NEWLINE = CP_W'(10);
    localparam logic [3:0]      SPACE_PX   = 4'd4;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    typedef struct packed {
        logic space;
        logic newline;
        logic narrow;
        logic beyond;
    } cp_flags_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        if (!b[7]) begin
            return 3'd1;
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
            return 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
            return 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
            return 3'd4;
        end else begin
            return 3'd1;
        end
    endfunction

    // (lo + 1 - hi) / 2 + 1 truncated toward zero, zero when not positive or when g is zero
    function automatic logic [3:0] glyph_width(input logic [7:0] g);
        logic signed [5:0] v;
        v = $signed({2'b00, g[3:0]}) - $signed({2'b00, g[7:4]}) + 6'sd1;
        if (g == 8'd0 || v < -6'sd1) begin
            return 4'd0;
        end else if (v < 6'sd0) begin
            return 4'd1;
        end else begin
            return v[4:1] + 4'd1;
        end
    endfunction

endpackage

// File: rtl/utf8_text_line_width.sv
// utf-8 text line width meter: takes bytes, reports the widest line in pixels
// one table write per cycle while idle; a text byte that completes a code point is
// decoded, then accumulated, as is each further code point of an end-of-string tail
// throughput is set by the shared decode and accumulate unit, one code point at a time
// after reset a clearing pass over every glyph entry zeroes both tables, tready low
// depends on utlw_pkg
module utf8_text_line_width #(
    parameter int GLYPH_ENTRIES = 65536,
    parameter int WIDTH_BITS    = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [utlw_pkg::S_DATA_W-1:0]  s_tdata,  // data_byte, table_index
    input  logic [utlw_pkg::S_USER_W-1:0]  s_tuser,  // cmd, wide_mode
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [utlw_pkg::M_DATA_W-1:0]  m_tdata   // max_width, saturated, zero pad
);
    import utlw_pkg::*;

    localparam int GI    = $clog2(GLYPH_ENTRIES);
    localparam int SUM_W = WIDTH_BITS + 1;
    localparam logic [CP_W-1:0] GLYPH_LIM_CP  = CP_W'(GLYPH_ENTRIES);
    localparam logic [16:0]     GLYPH_LIM_IDX = 17'(GLYPH_ENTRIES);
    localparam logic [GI-1:0]   CLR_LAST      = GI'(GLYPH_ENTRIES - 1);
    localparam logic [WIDTH_BITS-1:0] SUM_MAX = {WIDTH_BITS{1'b1}};

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_ACCUM  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [GI-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [1:0]            pcount_reg, pcount_next;
    logic [2:0]            nrem_reg, nrem_next;
    logic [7:0]            buf_reg [0:3];
    logic [7:0]            buf_next [0:3];
    logic                  last_reg, last_next;
    logic                  wide_reg, wide_next;
    cp_flags_t             flags_reg, flags_next;
    logic [WIDTH_BITS-1:0] sum_reg, sum_next;
    logic [WIDTH_BITS-1:0] widest_reg, widest_next;
    logic                  ovf_reg, ovf_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [7:0]            glyph_mem [0:GLYPH_ENTRIES-1];
    logic [3:0]            narrow_mem [0:NARROW_ENTRIES-1];
    logic [7:0]            glyph_rd_reg;
    logic [3:0]            narrow_rd_reg;

    logic [1:0]            cmd;
    logic [7:0]            data_byte;
    logic [15:0]           table_index;
    logic                  accept;

    logic                  glyph_we, narrow_we;
    logic [GI-1:0]         glyph_wa;
    logic [NARROW_AW-1:0]  narrow_wa;
    logic [7:0]            glyph_wd;
    logic [3:0]            narrow_wd;
    logic                  rd_en;

    logic [2:0]            lead_len, dec_len, used;
    logic [2:0]            n_after;
    logic [CP_W-1:0]       cp;
    logic [3:0]            px;
    logic [SUM_W-1:0]      sum_add;
    logic [WIDTH_BITS-1:0] line_top;
    logic                  out_free;

    assign cmd         = s_tuser[1:0];
    assign data_byte   = s_tdata[7:0];
    assign table_index = s_tdata[23:8];
    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign out_free    = !m_tvalid_reg || m_tready;

    // decode one code point from the head of the byte buffer
    always_comb begin
        dec_len = seq_len(buf_reg[0]);
        if (dec_len == 3'd1 || nrem_reg < dec_len) begin
            used = 3'd1;
        end else begin
            used = dec_len;
        end
        case (used)
            3'd2: cp = {10'd0, buf_reg[0][4:0], buf_reg[1][5:0]};
            3'd3: cp = {5'd0, buf_reg[0][3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            3'd4: cp = {buf_reg[0][2:0], buf_reg[1][5:0], buf_reg[2][5:0],
                        buf_reg[3][5:0]};
            default: cp = {13'd0, buf_reg[0]};
        endcase
    end

    always_comb begin
        if (flags_reg.space) begin
            px = SPACE_PX;
        end else if (flags_reg.narrow && !wide_reg) begin
            px = narrow_rd_reg;
        end else if (flags_reg.beyond) begin
            px = 4'd0;
        end else begin
            px = glyph_width(glyph_rd_reg);
        end
        sum_add  = {1'b0, sum_reg} + SUM_W'(px);
        line_top = (sum_reg > widest_reg) ? sum_reg : widest_reg;
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pcount_next   = pcount_reg;
        nrem_next     = nrem_reg;
        buf_next      = buf_reg;
        last_next     = last_reg;
        wide_next     = wide_reg;
        flags_next    = flags_reg;
        sum_next      = sum_reg;
        widest_next   = widest_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        glyph_we      = 1'b0;
        narrow_we     = 1'b0;
        glyph_wa      = table_index[GI-1:0];
        narrow_wa     = table_index[NARROW_AW-1:0];
        glyph_wd      = data_byte;
        narrow_wd     = data_byte[3:0];
        rd_en         = 1'b0;
        lead_len      = seq_len((pcount_reg == 2'd0) ? data_byte : buf_reg[0]);
        n_after       = {1'b0, pcount_reg} + 3'd1;

        case (state_reg)
            ST_CLEAR: begin
                glyph_we     = 1'b1;
                narrow_we    = 1'b1;
                glyph_wa     = clr_cnt_reg;
                narrow_wa    = clr_cnt_reg[NARROW_AW-1:0];
                glyph_wd     = 8'd0;
                narrow_wd    = 4'd0;
                clr_cnt_next = clr_cnt_reg + GI'(1);
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_NARROW: begin
                            narrow_we = (table_index[15:NARROW_AW] == '0);
                        end
                        CMD_GLYPH: begin
                            glyph_we = ({1'b0, table_index} < GLYPH_LIM_IDX);
                        end
                        CMD_TEXT: begin
                            buf_next[pcount_reg] = data_byte;
                            wide_next = s_tuser[2];
                            last_next = s_tlast;
                            if (s_tlast || n_after >= lead_len) begin
                                nrem_next   = n_after;
                                pcount_next = 2'd0;
                                state_next  = ST_DECODE;
                            end else begin
                                pcount_next = n_after[1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DECODE: begin
                rd_en              = 1'b1;
                flags_next.space   = (cp == CP_SPACE);
                flags_next.newline = (cp == CP_NEWLINE);
                flags_next.narrow  = (cp[CP_W-1:NARROW_AW] == '0);
                flags_next.beyond  = (cp >= GLYPH_LIM_CP);
                nrem_next          = nrem_reg - used;
                case (used)
                    3'd1: buf_next = '{buf_reg[1], buf_reg[2], buf_reg[3], 8'd0};
                    3'd2: buf_next = '{buf_reg[2], buf_reg[3], 8'd0, 8'd0};
                    3'd3: buf_next = '{buf_reg[3], 8'd0, 8'd0, 8'd0};
                    default: buf_next = '{8'd0, 8'd0, 8'd0, 8'd0};
                endcase
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (flags_reg.newline) begin
                    widest_next = line_top;
                    sum_next    = '0;
                end else if (px != 4'd0) begin
                    if (sum_add[WIDTH_BITS]) begin
                        sum_next = SUM_MAX;
                        ovf_next = 1'b1;
                    end else begin
                        sum_next = sum_add[WIDTH_BITS-1:0];
                    end
                end
                if (nrem_reg != 3'd0) begin
                    state_next = ST_DECODE;
                end else if (last_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, ovf_reg, 16'(line_top)};
                    sum_next      = '0;
                    widest_next   = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (glyph_we) begin
            glyph_mem[glyph_wa] <= glyph_wd;
        end
        if (narrow_we) begin
            narrow_mem[narrow_wa] <= narrow_wd;
        end
        if (rd_en) begin
            glyph_rd_reg  <= glyph_mem[cp[GI-1:0]];
            narrow_rd_reg <= narrow_mem[cp[NARROW_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pcount_reg   <= 2'd0;
            nrem_reg     <= 3'd0;
            last_reg     <= 1'b0;
            sum_reg      <= '0;
            widest_reg   <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pcount_reg   <= pcount_next;
            nrem_reg     <= nrem_next;
            last_reg     <= last_next;
            sum_reg      <= sum_next;
            widest_reg   <= widest_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg     <= buf_next;
        wide_reg    <= wide_next;
        flags_reg   <= flags_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: tb/tb.sv
// testbench for utf8_text_line_width: directed and random byte streams and table writes
// an in-bench line width predictor checks every result under several flow-control phases
// depends on utlw_pkg and the utf8_text_line_width rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utlw_pkg::*;

    localparam int GLYPH_ENTRIES = 4096;
    localparam int WIDTH_BITS    = 8;
    localparam int SUM_CAP       = (1 << WIDTH_BITS) - 1;
    localparam int QUIET_LIMIT   = 4 * GLYPH_ENTRIES + 4000;
    localparam int PHASE_ITEMS   = 420;
    localparam int TAIL_CYCLES   = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic [15:0] index;
        logic        wide;
        logic        last;
    } text_item_t;

    typedef struct packed {
        logic [15:0] max_width;
        logic        saturated;
    } line_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    text_item_t   stream_q [$];
    line_report_t widths_due [$];
    text_item_t   cur;
    line_report_t due;

    logic [3:0] narrow_px [NARROW_ENTRIES] = '{default: 4'h0};
    logic [7:0] glyph_sz [GLYPH_ENTRIES] = '{default: 8'h00};
    logic [7:0] held [3];
    int held_n = 0;
    int line_px = 0;
    int widest_px = 0;
    logic clipped = 1'b0;

    int gap_pct = 0;
    int stall_pct = 0;
    int n_queued = 0;
    int n_text = 0;
    int n_writes = 0;
    int n_checked = 0;
    int n_clipped = 0;
    int fails = 0;
    int quiet_cycles = 0;
    int send_gap [4] = '{0, 80, 0, 18};
    int sink_stall [4] = '{0, 0, 80, 18};

    utf8_text_line_width #(
        .GLYPH_ENTRIES(GLYPH_ENTRIES),
        .WIDTH_BITS   (WIDTH_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int lead_len(input logic [7:0] b);
        if (!b[7]) return 1;
        if ((b & LEAD2_MASK) == LEAD2_VAL) return 2;
        if ((b & LEAD3_MASK) == LEAD3_VAL) return 3;
        if ((b & LEAD4_MASK) == LEAD4_VAL) return 4;
        return 1;
    endfunction

    function automatic int decode_at(input logic [7:0] s [4], input int pos, input int n,
                                     output int unsigned cp);
        logic [7:0] c;
        int l;
        c = s[pos];
        l = lead_len(c);
        if (l == 1 || n - pos < l) begin
            cp = c;
            return 1;
        end
        case (l)
            2: cp = {c[4:0], s[pos+1][5:0]};
            3: cp = {c[3:0], s[pos+1][5:0], s[pos+2][5:0]};
            default: cp = {c[2:0], s[pos+1][5:0], s[pos+2][5:0], s[pos+3][5:0]};
        endcase
        return l;
    endfunction

    function automatic int point_px(input int unsigned cp, input logic wide);
        logic [7:0] g;
        int lo;
        int hi;
        if (cp == CP_SPACE) return SPACE_PX;
        if (cp <= 255 && !wide) return narrow_px[cp[7:0]];
        if (cp >= GLYPH_ENTRIES) return 0;
        g = glyph_sz[cp];
        if (g == 8'h00) return 0;
        lo = g[3:0];
        hi = g[7:4];
        return (lo + 1 - hi) / 2 + 1;
    endfunction

    function automatic void add_point(input int unsigned cp, input logic wide);
        int px;
        px = point_px(cp, wide);
        if (cp == CP_NEWLINE) begin
            if (line_px > widest_px) widest_px = line_px;
            line_px = 0;
        end else if (px > 0) begin
            line_px += px;
            if (line_px > SUM_CAP) begin
                line_px = SUM_CAP;
                clipped = 1'b1;
            end
        end
    endfunction

    task automatic measure_transfer(input logic [1:0] cmd, input logic [7:0] data,
                                    input logic [15:0] index, input logic wide,
                                    input logic last);
        logic [7:0] seq [4];
        int n;
        int pos;
        int i;
        int unsigned cp;
        line_report_t rep;
        case (cmd)
            CMD_NARROW: begin
                if (index < NARROW_ENTRIES) narrow_px[index[7:0]] = data[3:0];
                n_writes++;
            end
            CMD_GLYPH: begin
                if (index < GLYPH_ENTRIES) glyph_sz[index] = data;
                n_writes++;
            end
            CMD_TEXT: begin
                n_text++;
                n = held_n;
                for (i = 0; i < n; i++) seq[i] = held[i];
                seq[n] = data;
                n++;
                if (!last) begin
                    if (n >= lead_len(seq[0])) begin
                        void'(decode_at(seq, 0, n, cp));
                        add_point(cp, wide);
                        held_n = 0;
                    end else begin
                        for (i = 0; i < n; i++) held[i] = seq[i];
                        held_n = n;
                    end
                end else begin
                    pos = 0;
                    while (pos < n) begin
                        pos += decode_at(seq, pos, n, cp);
                        add_point(cp, wide);
                    end
                    if (line_px > widest_px) widest_px = line_px;
                    rep.max_width = 16'(widest_px);
                    rep.saturated = clipped;
                    widths_due.insert(widths_due.size(), rep);
                    if (clipped) n_clipped++;
                    line_px = 0;
                    widest_px = 0;
                    clipped = 1'b0;
                    held_n = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [15:0] index, input logic wide, input logic last);
        text_item_t it;
        it.cmd = cmd;
        it.data = data;
        it.index = index;
        it.wide = wide;
        it.last = last;
        stream_q.insert(stream_q.size(), it);
        n_queued++;
    endtask

    task automatic queue_write();
        int pick;
        logic [15:0] index;
        pick = $urandom_range(99);
        if (pick < 45) begin
            index = ($urandom_range(9) == 0) ? 16'($urandom) :
                    16'($urandom_range(NARROW_ENTRIES - 1));
            push_item(CMD_NARROW, 8'($urandom), index, 1'($urandom), 1'($urandom));
        end else if (pick < 90) begin
            pick = $urandom_range(9);
            if (pick < 7) index = 16'($urandom_range(255));
            else if (pick < 9) index = 16'($urandom_range(GLYPH_ENTRIES - 1));
            else index = 16'($urandom);
            push_item(CMD_GLYPH, 8'($urandom), index, 1'($urandom), 1'($urandom));
        end else begin
            push_item(CMD_UNUSED, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // emits the first keep bytes of a len-byte encoding of cp
    task automatic put_point(input int unsigned cp, input int len, input int keep,
                             input logic wide);
        logic [7:0] enc [4];
        int i;
        case (len)
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            4: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
            default: enc[0] = cp[7:0];
        endcase
        for (i = 0; i < keep; i++)
            push_item(CMD_TEXT, enc[i], 16'($urandom), wide ^ ($urandom_range(49) == 0), 1'b0);
    endtask

    task automatic queue_string();
        int n_pts;
        int nl_pct;
        int k;
        int kind;
        int len;
        int keep;
        int unsigned cp;
        logic wide;
        logic cut;
        wide = 1'($urandom);
        if ($urandom_range(99) < 8) begin
            n_pts = $urandom_range(100, 40);
            nl_pct = 2;
        end else begin
            n_pts = $urandom_range(8, 1);
            nl_pct = 10;
        end
        cut = ($urandom_range(6) == 0);
        for (k = 0; k < n_pts; k++) begin
            if ($urandom_range(19) == 0) wide = ~wide;
            if ($urandom_range(39) == 0) queue_write();
            kind = $urandom_range(99);
            len = 1;
            if (kind < nl_pct) begin
                cp = CP_NEWLINE;
            end else if (kind < 20) begin
                cp = CP_SPACE;
            end else if (kind < 40) begin
                cp = $urandom_range(127);
            end else if (kind < 58) begin
                cp = $urandom_range(255);
                len = 2;
            end else if (kind < 70) begin
                cp = $urandom_range(12'h7FF);
                len = 2;
            end else if (kind < 80) begin
                cp = $urandom_range(1) ? $urandom_range(GLYPH_ENTRIES - 1) :
                     $urandom_range(16'hFFFF);
                len = 3;
            end else if (kind < 88) begin
                cp = $urandom_range(21'h1FFFFF);
                len = 4;
            end else begin
                cp = $urandom_range(255);
            end
            keep = len;
            if (cut && k == n_pts - 1) begin
                len = $urandom_range(4, 2);
                keep = $urandom_range(len - 1, 1);
            end
            put_point(cp, len, keep, wide);
        end
        stream_q[stream_q.size() - 1].last = 1'b1;
    endtask

    task automatic drain();
        while (stream_q.size() != 0 || s_tvalid || widths_due.size() != 0)
            @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                cur = stream_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur.index, cur.data};
                s_tuser  <= {cur.wide, cur.cmd};
                s_tlast  <= cur.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                measure_transfer(s_tuser[1:0], s_tdata[7:0], s_tdata[23:8], s_tuser[2], s_tlast);
            if (m_tvalid && m_tready) begin
                if (widths_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result: max_width %0d saturated %0d",
                                 m_tdata[15:0], m_tdata[16]);
                end else begin
                    due = widths_due.pop_front();
                    n_checked++;
                    if (m_tdata[15:0] !== due.max_width || m_tdata[16] !== due.saturated ||
                        m_tdata[23:17] !== '0) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch on result %0d: max_width exp %0d got %0d, %s",
                                     n_checked, due.max_width, m_tdata[15:0],
                                     $sformatf("saturated exp %0d got %0d, pad %h",
                                               due.saturated, m_tdata[16], m_tdata[23:17]));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int ph;
        int target;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // table writes, including out-of-range indexes and the unused command
        push_item(CMD_NARROW, 8'hA5, 16'h0041, 1'b0, 1'b1);
        push_item(CMD_NARROW, 8'hFF, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_NARROW, 8'h3C, 16'h00FF, 1'b0, 1'b0);
        push_item(CMD_NARROW, 8'h77, 16'hFFFF, 1'b0, 1'b0);
        push_item(CMD_GLYPH, 8'h0F, 16'h03B1, 1'b0, 1'b0);
        push_item(CMD_GLYPH, 8'h84, 16'h00C3, 1'b0, 1'b0);
        push_item(CMD_GLYPH, 8'h31, 16'h0080, 1'b0, 1'b1);
        push_item(CMD_GLYPH, 8'hFF, 16'hF000, 1'b1, 1'b0);
        push_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
        // narrow string: letter, space, nul, newline, 0xff, 3-byte lead cut short at the end
        push_item(CMD_TEXT, 8'h41, 16'h0000, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h20, 16'h0000, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h00, 16'h0000, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'h0A, 16'h0000, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'hFF, 16'h0000, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'hE0, 16'h0000, 1'b0, 1'b0);
        push_item(CMD_TEXT, 8'hA0, 16'h0000, 1'b0, 1'b1);
        // wide string: 2-byte glyph, point past the glyph table, stray continuation,
        // newline, space, lone 2-byte lead at the end
        push_item(CMD_TEXT, 8'hCE, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'hB1, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'hF4, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'h8F, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'hBF, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'hBF, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'h80, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'h0A, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'h20, 16'h0000, 1'b1, 1'b0);
        push_item(CMD_TEXT, 8'hC3, 16'h0000, 1'b1, 1'b1);
        drain();

        repeat (80) push_item(CMD_NARROW, 8'($urandom), 16'($urandom_range(127)),
                              1'($urandom), 1'($urandom));
        repeat (80) push_item(CMD_GLYPH, 8'($urandom), 16'($urandom_range(255)),
                              1'($urandom), 1'($urandom));

        for (ph = 0; ph < 4; ph++) begin
            gap_pct = send_gap[ph];
            stall_pct = sink_stall[ph];
            target = n_queued + PHASE_ITEMS;
            while (n_queued < target) begin
                if ($urandom_range(9) == 0) repeat ($urandom_range(6, 1)) queue_write();
                queue_string();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        fails += widths_due.size();
        $display("sent %0d text bytes and %0d table writes; checked %0d line widths, %0d saturated",
                 n_text, n_writes, n_checked, n_clipped);
        $display("flow control: free running, sparse sender, stalling receiver, both mixed");
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/utlw_pkg.sv
rtl/utf8_text_line_width.sv
tb/tb.sv
